FILE: sv/ehdmt_pkg.sv
// ============================================================================
// ehdmt_pkg: shared types, constants and the hash fold for the ELF hash table
// Field widths, command codes, controller/datapath command and status
// structs, and the per-byte PJW/ELF fold.
// ============================================================================
package ehdmt_pkg;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 8;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 10;
    localparam int CFG_W   = 11;
    localparam int HASH_W  = 28;
    localparam int FOLD_W  = HASH_W + 4;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd100;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic fold;         // fold a non-final key byte into the accumulator
        logic capture;      // final byte: latch request, start the slot divide
        logic sweep_start;  // rewind the clear sweep pointer
        logic sweep_write;  // invalidate the entry under the sweep pointer
        logic mem_write;    // write add/remove data to the hashed slot
        logic mem_read;     // read the hashed slot
        logic out_load;     // load the response register
    } ehdmt_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic sweep_last;
        logic out_free;
        logic op_lookup;
    } ehdmt_sts_t;

    // One PJW/ELF step: shift in the byte, fold the top nibble back down.
    function automatic logic [HASH_W-1:0] fold_byte(
        input logic [HASH_W-1:0] acc,
        input logic [KEY_W-1:0]  key
    );
        logic [FOLD_W-1:0] h;
        begin
            h = {acc, 4'b0000} + FOLD_W'(key);
            return h[HASH_W-1:0] ^ HASH_W'({h[FOLD_W-1:HASH_W], 4'b0000});
        end
    endfunction

endpackage

FILE: sv/ehdmt_div.sv
// ============================================================================
// ehdmt_div: iterative remainder unit
// Restoring division, one dividend bit per cycle; keeps only the remainder.
// ============================================================================
module ehdmt_div #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVS_W-1:0] remainder
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   dvs_ext;
    logic             trial_ge;
    logic [DVS_W-1:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign dvs_ext  = {1'b0, dvs_reg};
    assign trial_ge = (trial >= dvs_ext);

    // remainder stays below the divisor, so the difference always fits
    always_comb begin
        if (trial_ge) begin
            rem_next = DVS_W'(trial - dvs_ext);
        end else begin
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/ehdmt_ctrl.sv
// ============================================================================
// ehdmt_ctrl: request sequencer
// Steps each final-byte lookup, add or remove request through divide, table
// access and response; runs the table clear sweep after reset and on a clear request.
// ============================================================================
module ehdmt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_key_last,
    input  logic [ehdmt_pkg::CMD_W-1:0] s_cmd,
    output logic                   s_ready,
    output ehdmt_pkg::ehdmt_ctl_t  ctl,
    input  ehdmt_pkg::ehdmt_sts_t  sts
);
    import ehdmt_pkg::*;

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ACCESS = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_CLR: begin
                ctl.sweep_write = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_key_last) begin
                        ctl.fold = 1'b1;
                    end else begin
                        ctl.capture = 1'b1;
                        if (s_cmd == CMD_CLEAR) begin
                            ctl.sweep_start = 1'b1;
                            state_next      = ST_CLR;
                        end else begin
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (sts.op_lookup) begin
                    ctl.mem_read = 1'b1;
                end else begin
                    ctl.mem_write = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: sv/ehdmt_dp.sv
// ============================================================================
// ehdmt_dp: hash, slot and table datapath
// Hash accumulator, size register, slot divider, entry memory with a valid
// bit per word, clear sweep pointer and response register.
// ============================================================================
module ehdmt_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ehdmt_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [ehdmt_pkg::CMD_W-1:0]    s_cmd,
    input  logic [ehdmt_pkg::KEY_W-1:0]    s_key_byte,
    input  logic [ehdmt_pkg::VALUE_W-1:0]  s_write_value,
    input  ehdmt_pkg::ehdmt_ctl_t          ctl,
    output ehdmt_pkg::ehdmt_sts_t          sts,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [ehdmt_pkg::SLOT_W-1:0]   m_slot_index,
    output logic [ehdmt_pkg::VALUE_W-1:0]  m_read_value
);
    import ehdmt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = $clog2(TABLE_DEPTH + 1);

    logic [CFG_W-1:0]      table_size_reg;
    logic [HASH_W-1:0]     acc_reg;
    logic [HASH_W-1:0]     hash_fold;
    logic [CMD_W-1:0]      cmd_reg;
    logic [DATA_WIDTH-1:0] wval_reg;
    logic [DW-1:0]         divisor;
    logic [DW-1:0]         rem;
    logic                  div_busy;
    logic [AW-1:0]         slot;
    logic [AW-1:0]         sweep_reg;

    logic [DATA_WIDTH:0]   mem_ram [TABLE_DEPTH];
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH:0]   mem_wdata;
    logic [DATA_WIDTH:0]   rd_reg;
    logic [DATA_WIDTH-1:0] result_value;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic [VALUE_W-1:0]    m_value_reg;

    assign hash_fold = fold_byte(acc_reg, s_key_byte);

    // active slot count: zero counts as one, saturate at the table depth
    always_comb begin
        if (table_size_reg == '0) begin
            divisor = DW'(1);
        end else if (int'(table_size_reg) > TABLE_DEPTH) begin
            divisor = DW'(TABLE_DEPTH);
        end else begin
            divisor = DW'(table_size_reg);
        end
    end

    ehdmt_div #(
        .DVD_W (HASH_W),
        .DVS_W (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctl.capture),
        .dividend  (hash_fold),
        .divisor   (divisor),
        .busy      (div_busy),
        .remainder (rem)
    );

    assign slot = rem[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RST;
            acc_reg        <= '0;
            sweep_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                table_size_reg <= cfg_wr_data;
            end
            if (ctl.capture) begin
                acc_reg <= '0;
            end else if (ctl.fold) begin
                acc_reg <= hash_fold;
            end
            if (ctl.sweep_start) begin
                sweep_reg <= '0;
            end else if (ctl.sweep_write) begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid_next = ctl.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg  <= s_cmd;
            wval_reg <= DATA_WIDTH'(s_write_value);
        end
    end

    // sweep writes an invalid word; add/remove write a valid one
    always_comb begin
        mem_we = ctl.sweep_write | ctl.mem_write;
        if (ctl.sweep_write) begin
            mem_addr  = sweep_reg;
            mem_wdata = '0;
        end else begin
            mem_addr = slot;
            if (cmd_reg == CMD_ADD) begin
                mem_wdata = {1'b1, wval_reg};
            end else begin
                mem_wdata = {1'b1, {DATA_WIDTH{1'b0}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_addr] <= mem_wdata;
        end
        if (ctl.mem_read) begin
            rd_reg <= mem_ram[slot];
        end
    end

    always_comb begin
        unique case (cmd_reg)
            CMD_LOOKUP: result_value = rd_reg[DATA_WIDTH] ? rd_reg[DATA_WIDTH-1:0] : '0;
            CMD_ADD:    result_value = wval_reg;
            CMD_REMOVE,
            CMD_CLEAR:  result_value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_slot_reg  <= SLOT_W'(slot);
            m_value_reg <= VALUE_W'(result_value);
        end
    end

    assign sts.div_busy   = div_busy;
    assign sts.sweep_last = (sweep_reg == AW'(TABLE_DEPTH - 1));
    assign sts.out_free   = ~m_valid_reg | m_ready;
    assign sts.op_lookup  = (cmd_reg == CMD_LOOKUP);

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_slot_reg;
    assign m_read_value = m_value_reg;

endmodule

FILE: sv/elf_hash_direct_mapped_table_core.sv
// ============================================================================
// elf_hash_direct_mapped_table_core: PJW/ELF hashed direct-mapped table
// Keys stream in one byte per request with a last-byte flag; each byte folds
// into a PJW/ELF hash as it is taken, so non-final bytes are taken back to
// back. On the final byte the hash is reduced modulo the active table size
// by a bit-serial remainder unit (one hash bit per cycle), then the slot is
// looked up, overwritten (add) or zeroed (remove) in a single-port entry
// memory, and one response carries the slot and its contents. A final byte
// therefore holds off the next request through capture, one divide step per
// hash bit, a state to see the divider finish, the memory access and the
// response load, which waits longer while the previous response is still
// held. Responses sit in an output register, so key bytes of the next
// request keep flowing while a response waits. A clear request zeroes every
// entry and gives no response; like the sweep that follows reset it walks the
// memory one entry per cycle, with the input held off. A table_size of zero
// acts as one, and a value above TABLE_DEPTH acts as TABLE_DEPTH. Write
// table_size only while the block is idle.
// ============================================================================
module elf_hash_direct_mapped_table_core #(
    parameter int TABLE_DEPTH = ehdmt_pkg::TABLE_DEPTH_DEF,
    parameter int DATA_WIDTH  = ehdmt_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // table_size register
    input  logic                           cfg_wr_en,
    input  logic [ehdmt_pkg::CFG_W-1:0]    cfg_wr_data,
    // key byte requests
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ehdmt_pkg::CMD_W-1:0]    s_cmd,
    input  logic [ehdmt_pkg::KEY_W-1:0]    s_key_byte,
    input  logic                           s_key_last,
    input  logic [ehdmt_pkg::VALUE_W-1:0]  s_write_value,
    // responses
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ehdmt_pkg::SLOT_W-1:0]   m_slot_index,
    output logic [ehdmt_pkg::VALUE_W-1:0]  m_read_value
);
    import ehdmt_pkg::*;

    ehdmt_ctl_t ctl;
    ehdmt_sts_t sts;

    // Sequence requests: fold, divide, access, respond, or sweep on clear
    ehdmt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_key_last (s_key_last),
        .s_cmd      (s_cmd),
        .s_ready    (s_ready),
        .ctl        (ctl),
        .sts        (sts)
    );

    // Hold the hash, size register, entry memory and response register
    ehdmt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_cmd         (s_cmd),
        .s_key_byte    (s_key_byte),
        .s_write_value (s_write_value),
        .ctl           (ctl),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_slot_index  (m_slot_index),
        .m_read_value  (m_read_value)
    );

endmodule

FILE: sim/elf_hash_direct_mapped_table_core_tb.sv
// ============================================================================
// elf_hash_direct_mapped_table_core_tb: self-checking bench for the ELF table
// Streams keys one byte per request, keeps its own copy of the hash and of
// the slot store, and checks every response against the predicted slot and
// contents. Runs several table sizes; all but one phase has random gaps.
// ============================================================================
module elf_hash_direct_mapped_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ehdmt_pkg::*;

    localparam int SLOTS_MAX   = TABLE_DEPTH_DEF;
    localparam int IDLE_PCT    = 18;
    localparam int DRAIN_WAIT  = 1200;       // clear sweep plus a final-byte pass
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} key_fill_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key_byte;
        logic               key_last;
        logic [VALUE_W-1:0] write_value;
    } key_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } slot_resp_t;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data   = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd         = CMD_LOOKUP;
    logic [KEY_W-1:0]    s_key_byte    = '0;
    logic                s_key_last    = 1'b0;
    logic [VALUE_W-1:0]  s_write_value = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [SLOT_W-1:0]   m_slot_index;
    logic [VALUE_W-1:0]  m_read_value;

    // Requests waiting to go out, and responses the table must still return.
    key_req_t   req_pending[$];
    slot_resp_t resp_expected[$];

    // Shadow of the block: running hash, slot contents, valid bits, size.
    logic [HASH_W-1:0]   key_hash = '0;
    logic [VALUE_W-1:0]  slot_value [SLOTS_MAX];
    bit                  slot_live  [SLOTS_MAX];
    logic [CFG_W-1:0]    table_slots = TABLE_SIZE_RST;

    bit                  no_idle   = 1'b0;
    int unsigned         errors    = 0;
    int unsigned         cycles    = 0;

    elf_hash_direct_mapped_table_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_key_byte    (s_key_byte),
        .s_key_last    (s_key_last),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot_index  (m_slot_index),
        .m_read_value  (m_read_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Shift the byte in, then fold the top nibble back into bits 7:4.
    function automatic logic [HASH_W-1:0] elf_fold(input logic [HASH_W-1:0] acc,
                                                   input logic [KEY_W-1:0] kb);
        logic [31:0] h;
        logic [31:0] top;
        h   = {acc, 4'b0000} + {24'd0, kb};
        top = h & 32'hF000_0000;
        if (top != 32'd0) begin
            h = h ^ (top >> 24);
            h = h & ~top;
        end
        return h[HASH_W-1:0];
    endfunction

    // Clamp the register to the range of usable slots.
    function automatic int unsigned active_slots(input logic [CFG_W-1:0] sz);
        if (sz == '0)
            return 1;
        if (sz > SLOTS_MAX)
            return SLOTS_MAX;
        return sz;
    endfunction

    // Queue one whole key. Non-final bytes carry random cmd and value, which
    // the block must ignore. Return the number of bytes queued.
    function automatic int queue_key(input logic [CMD_W-1:0] op, input int len,
                                     input key_fill_t fill,
                                     input logic [VALUE_W-1:0] wval);
        key_req_t          r;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: r.key_byte = 8'h00;
                FILL_ONES: r.key_byte = 8'hFF;
                default:   r.key_byte = KEY_W'($urandom);
            endcase
            r.key_last    = (i == len - 1);
            r.cmd         = CMD_W'($urandom);
            r.write_value = $urandom;
            if (r.key_last) begin
                r.cmd         = op;
                r.write_value = wval;
            end
            req_pending.push_back(r);
        end
        return len;
    endfunction

    // Wait until every request is out and every response is back, then give
    // a clear sweep time to finish.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (req_pending.size() != 0 || s_valid || resp_expected.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Driver: on acceptance, advance the shadow and record the response;
    // then present the next request, or drop valid for an idle cycle.
    always @(posedge aclk) begin : drive_requests
        logic [HASH_W-1:0] h;
        int unsigned       slot;
        slot_resp_t        e;
        key_req_t          r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                h = elf_fold(key_hash, s_key_byte);
                if (!s_key_last) begin
                    key_hash = h;
                end else begin
                    key_hash = '0;
                    slot     = h % active_slots(table_slots);
                    if (s_cmd == CMD_CLEAR) begin
                        // clear: drop every valid bit, no response
                        for (int i = 0; i < SLOTS_MAX; i++)
                            slot_live[i] = 1'b0;
                    end else begin
                        if (s_cmd == CMD_ADD) begin
                            slot_value[slot] = s_write_value;
                            slot_live[slot]  = 1'b1;
                        end else if (s_cmd == CMD_REMOVE) begin
                            // remove leaves the slot valid and holding zero
                            slot_value[slot] = '0;
                            slot_live[slot]  = 1'b1;
                        end
                        e.slot  = SLOT_W'(slot);
                        e.value = slot_live[slot] ? slot_value[slot] : '0;
                        resp_expected.push_back(e);
                    end
                end
            end
            // Hold the payload while the request waits; otherwise reload.
            if (!s_valid || s_ready) begin
                if (req_pending.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    r = req_pending.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= r.cmd;
                    s_key_byte    <= r.key_byte;
                    s_key_last    <= r.key_last;
                    s_write_value <= r.write_value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted response against the oldest expectation,
    // and stall the response channel at random.
    always @(posedge aclk) begin : check_responses
        slot_resp_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (resp_expected.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got slot %0d value %h",
                             $time, m_slot_index, m_read_value);
                    errors++;
                end else begin
                    e = resp_expected.pop_front();
                    if (m_slot_index !== e.slot) begin
                        $display("%0t: slot_index mismatch, expected %0d, got %0d",
                                 $time, e.slot, m_slot_index);
                        errors++;
                    end
                    if (m_read_value !== e.value) begin
                        $display("%0t: read_value mismatch, expected %h, got %h",
                                 $time, e.value, m_read_value);
                        errors++;
                    end
                end
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : run_phases
        logic [CFG_W-1:0] size_plan [8];
        int               budget    [8];
        int               queued;
        int               pick;
        int               len;
        logic [CMD_W-1:0] op;

        // Reset value first, then the extremes: zero acts as one, 2047
        // saturates, then a few sizes in between.
        size_plan = '{TABLE_SIZE_RST, 11'd0, 11'd2047, 11'd1, 11'd1024,
                      11'd7, 11'd1023, CFG_W'($urandom_range(2, 1022))};
        budget    = '{200, 150, 400, 150, 350, 200, 200, 200};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            if (p != 0) begin
                // Write the size only with the table idle.
                wait_drained();
                @(posedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= size_plan[p];
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                table_slots = size_plan[p];
            end
            // Run the 1024-slot phase with no gaps on either side.
            no_idle = (p == 2);
            queued  = 0;
            if (p == 0) begin
                // Directed: lookup of an empty slot, slot 0 with an all-ones
                // value, a one-byte key of 0xFF, a key long enough to fold,
                // remove, clear, then lookups of cleared slots.
                queued += queue_key(CMD_LOOKUP, 1, FILL_ZERO,   32'h0);
                queued += queue_key(CMD_ADD,    1, FILL_ZERO,   32'hFFFF_FFFF);
                queued += queue_key(CMD_LOOKUP, 1, FILL_ZERO,   32'h0);
                queued += queue_key(CMD_ADD,    1, FILL_ONES,   32'h0);
                queued += queue_key(CMD_ADD,    7, FILL_ONES,   32'hA5A5_5A5A);
                queued += queue_key(CMD_REMOVE, 7, FILL_ONES,   32'hFFFF_FFFF);
                queued += queue_key(CMD_CLEAR,  1, FILL_RANDOM, 32'hFFFF_FFFF);
                queued += queue_key(CMD_LOOKUP, 1, FILL_ZERO,   32'h0);
                queued += queue_key(CMD_LOOKUP, 1, FILL_ONES,   32'h0);
            end
            while (queued < budget[p]) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = CMD_LOOKUP;
                else if (pick < 72)
                    op = CMD_ADD;
                else if (pick < 94)
                    op = CMD_REMOVE;
                else
                    op = CMD_CLEAR;
                // Mostly short keys, some long enough to overflow the hash.
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    len = $urandom_range(1, 4);
                else if (pick < 95)
                    len = $urandom_range(5, 10);
                else
                    len = $urandom_range(11, 40);
                queued += queue_key(op, len, FILL_RANDOM, $urandom);
            end
        end

        wait_drained();
        if (resp_expected.size() != 0)
            errors++;
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: elf_hash_direct_mapped_table_core.f
sv/ehdmt_pkg.sv
sv/ehdmt_div.sv
sv/ehdmt_ctrl.sv
sv/ehdmt_dp.sv
sv/elf_hash_direct_mapped_table_core.sv
sim/elf_hash_direct_mapped_table_core_tb.sv
